### rtl/sfr_pkg.sv
// sfr_pkg: shared types and register codes for stream_find_replace.
// No dependencies; every other file of the block but sfr_stream_if refers to it by scoped names.
`timescale 1ns / 1ps

package sfr_pkg;

  // Widest replacement or pattern is eight bytes.
  localparam int MaxBytes = 8;
  localparam int CountW   = 4;

  // Configuration register indexes.
  localparam logic [1:0] REG_MATCH_PATTERN  = 2'd0;
  localparam logic [1:0] REG_MATCH_LENGTH   = 2'd1;
  localparam logic [1:0] REG_REPLACE_TEXT   = 2'd2;
  localparam logic [1:0] REG_REPLACE_LENGTH = 2'd3;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       out_last;
  } out_item_t;

  // One classified item: bytes to emit (first in the low octet), how many, end flag.
  // A count of zero with last set is a bare end mark.
  typedef struct packed {
    logic [8*MaxBytes-1:0] bytes;
    logic [CountW-1:0]     count;
    logic                  last;
  } job_t;

endpackage

### rtl/sfr_stream_if.sv
// sfr_stream_if: valid/ready channel carrying one payload per transfer.
// Depends on nothing; payload type is set per instance (types from sfr_pkg).
`timescale 1ns / 1ps

interface sfr_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/sfr_front.sv
// sfr_front: accepts text bytes, keeps the pending window, classifies each byte into a job.
// Depends on sfr_pkg and sfr_stream_if.
`timescale 1ns / 1ps

module sfr_front #(
  parameter int MAX_TEXT_LEN = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic [1:0]  wr_index,
  input  logic [63:0] wr_data,
  sfr_stream_if.sink   text_in,
  sfr_stream_if.source job_out
);

  localparam int LenCap = (MAX_TEXT_LEN < sfr_pkg::MaxBytes) ? MAX_TEXT_LEN : sfr_pkg::MaxBytes;
  localparam int WinW   = 8 * LenCap;
  localparam int CntW   = $clog2(LenCap + 1);
  localparam int CW     = sfr_pkg::CountW;

  logic [63:0]   match_pattern;
  logic [CW-1:0] match_length;
  logic [63:0]   replace_text;
  logic [CW-1:0] replace_length;

  logic [WinW-1:0] window;
  logic [CntW-1:0] cnt;

  logic [CW-1:0]   mlen, rlen, c1;
  logic [CntW-1:0] c0, cnt_next;
  logic [WinW-1:0] win_new, win_next, mask;
  logic            full, hit, accept;
  logic [7:0]      b;
  logic            last;
  sfr_pkg::job_t   job;

  assign b      = text_in.data.in_byte;
  assign last   = text_in.data.in_last;
  assign accept = text_in.valid && text_in.ready;

  always_comb begin
    mlen = match_length;
    if (mlen == '0) mlen = CW'(1);
    if (mlen > CW'(LenCap)) mlen = CW'(LenCap);
    rlen = replace_length;
    if (rlen > CW'(LenCap)) rlen = CW'(LenCap);

    c0 = (CW'(cnt) >= mlen) ? '0 : cnt;
    c1 = CW'(c0) + CW'(1);

    for (int i = 0; i < LenCap; i++) begin
      win_new[8*i +: 8] = (CW'(i) == CW'(c0)) ? b : window[8*i +: 8];
      mask[8*i +: 8]    = (CW'(i) < mlen) ? 8'hFF : 8'h00;
    end

    full = (c1 == mlen);
    hit  = full && (((win_new ^ match_pattern[WinW-1:0]) & mask) == '0);

    job.last  = last;
    job.bytes = hit ? replace_text : 64'(win_new);
    if (hit)       job.count = rlen;
    else if (last) job.count = c1;
    else if (full) job.count = CW'(1);
    else           job.count = '0;

    if (last || hit) cnt_next = '0;
    else if (full)   cnt_next = CntW'(mlen - CW'(1));
    else             cnt_next = CntW'(c1);

    win_next = (full && !hit) ? (win_new >> 8) : win_new;
  end

  // Bytes that still wait on the window yield no job.
  assign job_out.valid = text_in.valid && ((job.count != '0) || last);
  assign job_out.data  = job;
  assign text_in.ready = job_out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      match_pattern  <= '0;
      match_length   <= CW'(1);
      replace_text   <= '0;
      replace_length <= '0;
      cnt            <= '0;
    end else begin
      // A length write drops the pending bytes.
      if (wr_en && (wr_index == sfr_pkg::REG_MATCH_LENGTH)) cnt <= '0;
      else if (accept)                                       cnt <= cnt_next;
      if (wr_en) begin
        case (wr_index)
          sfr_pkg::REG_MATCH_PATTERN:  match_pattern  <= wr_data;
          sfr_pkg::REG_MATCH_LENGTH:   match_length   <= wr_data[CW-1:0];
          sfr_pkg::REG_REPLACE_TEXT:   replace_text   <= wr_data;
          sfr_pkg::REG_REPLACE_LENGTH: replace_length <= wr_data[CW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) window <= win_next;
  end

  // Between bytes the window always holds fewer bytes than the pattern.
  a_window_short: assert property (@(posedge clk) disable iff (rst) CW'(cnt) < mlen)
    else $error("pending window reached pattern length between bytes");

endmodule

### rtl/sfr_queue.sv
// sfr_queue: two-entry job queue between the classifier and the emitter.
// Depends on sfr_pkg and sfr_stream_if.
`timescale 1ns / 1ps

module sfr_queue (
  input  logic         clk,
  input  logic         rst,
  sfr_stream_if.sink   push_if,
  sfr_stream_if.source pop_if
);

  sfr_pkg::job_t entry [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       push, pop;

  assign push_if.ready = (count != 2'd2);
  assign pop_if.valid  = (count != 2'd0);
  assign pop_if.data   = entry[rd_ptr];
  assign push = push_if.valid && push_if.ready;
  assign pop  = pop_if.valid && pop_if.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) entry[wr_ptr] <= push_if.data;
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("job queue occupancy out of range");

endmodule

### rtl/sfr_back.sv
// sfr_back: output register that plays out each job one byte per transfer.
// Depends on sfr_pkg and sfr_stream_if.
`timescale 1ns / 1ps

module sfr_back (
  input  logic         clk,
  input  logic         rst,
  sfr_stream_if.sink   job_in,
  sfr_stream_if.source text_out
);

  localparam int CW = sfr_pkg::CountW;

  logic                             busy;
  logic [8*sfr_pkg::MaxBytes-1:0]   bytes;
  logic [CW-1:0]                    rem;
  logic                             last;
  logic                             done, load;

  assign done = busy && text_out.ready && (rem <= CW'(1));
  assign job_in.ready = !busy || done;
  assign load = job_in.valid && job_in.ready;

  // A bare end mark carries a zero byte.
  assign text_out.valid          = busy;
  assign text_out.data.out_byte  = (rem != '0) ? bytes[7:0] : 8'h00;
  assign text_out.data.out_valid = (rem != '0);
  assign text_out.data.out_last  = last && (rem <= CW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (load) begin
      busy <= 1'b1;
    end else if (done) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bytes <= job_in.data.bytes;
      rem   <= job_in.data.count;
      last  <= job_in.data.last;
    end else if (busy && text_out.ready) begin
      bytes <= bytes >> 8;
      rem   <= rem - CW'(1);
    end
  end

  // A job without bytes can only be the end mark of a text.
  a_bare_is_last: assert property (@(posedge clk) disable iff (rst)
    busy && (rem == '0) |-> last)
    else $error("bare result without end of text");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    busy && !text_out.ready |=> busy && $stable(rem) && $stable(bytes))
    else $error("job progressed while output stalled");

endmodule

### rtl/stream_find_replace.sv
// stream_find_replace: streaming find-and-replace on a byte stream.
// Depends on sfr_pkg, sfr_stream_if, sfr_front, sfr_queue and sfr_back.
// A byte that yields output passes through the job queue and then the output register.
// Throughput: one input byte per cycle while the job queue has room; a byte that yields k
// results holds the emitter for k output transfers, and the two-entry job queue absorbs the
// difference until the input is stalled.
// Reset (rst, synchronous): registers take their reset values, window and queue empty at once.
`timescale 1ns / 1ps

module stream_find_replace #(
  parameter int MAX_TEXT_LEN = 8
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration writes: index picks the register, data is its new value.
  input  logic        wr_en,
  input  logic [1:0]  wr_index,
  input  logic [63:0] wr_data,
  sfr_stream_if.sink   text_in,
  sfr_stream_if.source text_out
);

  // Front to queue, and queue to back: one classified job per transfer.
  sfr_stream_if #(.payload_t(sfr_pkg::job_t)) front_job ();
  sfr_stream_if #(.payload_t(sfr_pkg::job_t)) back_job ();

  // Front: holds the configuration and the pending window. For each byte it
  // decides combinationally whether the window matched (emit the replacement),
  // overflowed (emit the oldest byte) or still waits, and on the final byte
  // folds the flushed window into the same job.
  sfr_front #(.MAX_TEXT_LEN(MAX_TEXT_LEN)) u_front (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .text_in  (text_in),
    .job_out  (front_job)
  );

  // Short queue: lets the front keep taking bytes while a replacement plays out.
  sfr_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push_if (front_job),
    .pop_if  (back_job)
  );

  // Back: output register; one byte per transfer, the last one carries out_last,
  // an empty final job becomes a bare end mark.
  sfr_back u_back (
    .clk      (clk),
    .rst      (rst),
    .job_in   (back_job),
    .text_out (text_out)
  );

endmodule
